// File: rtl/djb2_pkg.sv
package djb2_pkg;

   localparam int TableDepth = 1024;
   localparam int SlotBits   = $clog2(TableDepth);
   localparam int CountBits  = $clog2(TableDepth + 1);
   localparam int KeyBytes   = 8;
   localparam int KeyBits    = 8 * KeyBytes;
   localparam int LenBits    = 4;
   localparam int ValueBits  = 32;
   localparam int HashBits   = 32;
   localparam logic [HashBits-1:0] HashSeed = 32'd5381;

   localparam logic [1:0] ReqInsert = 2'd0;
   localparam logic [1:0] ReqLookup = 2'd1;
   localparam logic [1:0] ReqDelete = 2'd2;

   localparam logic [1:0] TagEmpty = 2'd0;
   localparam logic [1:0] TagLive  = 2'd1;
   localparam logic [1:0] TagTomb  = 2'd2;

   localparam logic [2:0] StInserted  = 3'd0;
   localparam logic [2:0] StDuplicate = 3'd1;
   localparam logic [2:0] StFound     = 3'd2;
   localparam logic [2:0] StAbsent    = 3'd3;
   localparam logic [2:0] StDeleted   = 3'd4;
   localparam logic [2:0] StFull      = 3'd5;

   localparam int QueueDepth = 2;

   // classified request handed from front to back
   typedef struct packed {
      logic [1:0]          req_type;
      logic [KeyBits-1:0]  key;
      logic [LenBits-1:0]  len;
      logic [ValueBits-1:0] value;
      logic [SlotBits-1:0] home;
   } job_type;

   localparam int JobBits = $bits(job_type);

   // slot record in the data store: key, length, value
   localparam int RecBits = KeyBits + LenBits + ValueBits;

endpackage

// File: rtl/djb2_linear_probe_hash_table_unit.sv
// Flow: each request is hashed in the front, waits in the queue, and is then probed
// slot by slot in the back until its result is offered.
// The front can hash the next request while the back probes an earlier one,
// as long as the queue has room.
// Reset: synchronous; after reset the back clears every slot tag, during which
// the front still takes up to three requests but none is probed.
module djb2_linear_probe_hash_table_unit import djb2_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [103:0] req_tdata,  // req_type, key_bytes, key_len, value_in, zero pad
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [55:0]  rsp_tdata   // status, slot_index, value_out, occupied_count
);

   logic    f_valid, f_ready, b_valid, b_ready;
   job_type f_job, b_job;

   djb2_front u_front (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata,
      .job_valid(f_valid), .job_ready(f_ready), .job(f_job)
   );

   djb2_queue u_queue (
      .clock, .reset, .in_valid(f_valid), .in_ready(f_ready), .in_job(f_job),
      .out_valid(b_valid), .out_ready(b_ready), .out_job(b_job)
   );

   djb2_back u_back (
      .clock, .reset, .job_valid(b_valid), .job_ready(b_ready), .job(b_job),
      .rsp_tvalid, .rsp_tready, .rsp_tdata
   );

endmodule

// File: rtl/djb2_ram.sv
module djb2_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/djb2_front.sv
module djb2_front import djb2_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [103:0]       req_tdata,
   output logic               job_valid,
   input  logic               job_ready,
   output job_type            job
);

   typedef enum logic [1:0] {S_IDLE, S_HASH, S_SEND} state_type;

   state_type state_ff;
   logic [3:0] idx_ff;
   logic [HashBits-1:0] hash_ff;
   job_type job_ff;

   logic [LenBits-1:0]   len_in;
   logic [KeyBits-1:0]   key_in;
   logic [7:0]           byte_sel;

   // clamp length and mask stray bytes
   always_comb begin
      len_in = req_tdata[69:66];
      if (len_in > LenBits'(KeyBytes)) len_in = LenBits'(KeyBytes);
      for (int b = 0; b < KeyBytes; b++) begin
         key_in[8*b +: 8] = (LenBits'(b) < len_in) ? req_tdata[2+8*b +: 8] : 8'd0;
      end
   end

   assign byte_sel = job_ff.key[8*idx_ff[2:0] +: 8];

   // one byte of djb2 per cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  job_ff.req_type <= req_tdata[1:0];
                  job_ff.key      <= key_in;
                  job_ff.len      <= len_in;
                  job_ff.value    <= req_tdata[101:70];
                  hash_ff         <= HashSeed;
                  idx_ff          <= 4'd0;
                  state_ff        <= S_HASH;
               end
            end
            S_HASH: begin
               if (idx_ff == job_ff.len) begin
                  job_ff.home <= hash_ff[SlotBits-1:0];
                  state_ff    <= S_SEND;
               end else begin
                  hash_ff <= (hash_ff << 5) + hash_ff + {24'd0, byte_sel};
                  idx_ff  <= idx_ff + 4'd1;
               end
            end
            S_SEND: begin
               if (job_ready) state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign job_valid  = (state_ff == S_SEND);
   assign job        = job_ff;

endmodule

// File: rtl/djb2_queue.sv
module djb2_queue import djb2_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  job_type in_job,
   output logic    out_valid,
   input  logic    out_ready,
   output job_type out_job
);

   localparam int PtrBits = $clog2(QueueDepth);

   job_type              buf_ff [QueueDepth];
   logic [PtrBits-1:0]   wr_ff, rd_ff;
   logic [PtrBits:0]     cnt_ff;
   logic                 push, pop;

   assign in_ready  = (cnt_ff != (PtrBits+1)'(QueueDepth));
   assign out_valid = (cnt_ff != '0);
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;
   assign out_job   = buf_ff[rd_ff];

   // small FIFO between classifier and probe engine
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) begin
            buf_ff[wr_ff] <= in_job;
            wr_ff <= wr_ff + 1'b1;
         end
         if (pop) rd_ff <= rd_ff + 1'b1;
         cnt_ff <= cnt_ff + (PtrBits+1)'(push) - (PtrBits+1)'(pop);
      end
   end

endmodule

// File: rtl/djb2_back.sv
module djb2_back import djb2_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         job_valid,
   output logic         job_ready,
   input  job_type      job,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [55:0]  rsp_tdata
);

   typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_READ, S_CHECK, S_WRITE, S_OUT}
      state_type;

   state_type state_ff;
   job_type   job_ff;
   logic [SlotBits-1:0]  addr_ff;
   logic [SlotBits:0]    visited_ff;
   logic                 hit_ff, have_free_ff;
   logic [SlotBits-1:0]  hit_slot_ff, free_slot_ff;
   logic [CountBits-1:0] count_ff;
   logic [2:0]           status_ff;
   logic [SlotBits-1:0]  slot_out_ff;
   logic [ValueBits-1:0] val_out_ff;

   logic                 tag_we, rec_we;
   logic [SlotBits-1:0]  tag_waddr;
   logic [1:0]           tag_wdata, tag_rd;
   logic [RecBits-1:0]   rec_rd;
   logic [KeyBits-1:0]   rd_key;
   logic [LenBits-1:0]   rd_len;
   logic [ValueBits-1:0] rd_val;
   logic                 match;

   assign {rd_val, rd_len, rd_key} = rec_rd;
   assign match = (tag_rd == TagLive) && (rd_len == job_ff.len) && (rd_key == job_ff.key);

   // store writes: clearing pass, insert, tombstone
   always_comb begin
      tag_we    = 1'b0;
      tag_waddr = addr_ff;
      tag_wdata = TagEmpty;
      rec_we    = 1'b0;
      if (state_ff == S_CLEAR) begin
         tag_we = 1'b1;
      end else if (state_ff == S_WRITE) begin
         if (job_ff.req_type == ReqInsert && !hit_ff && have_free_ff) begin
            tag_we = 1'b1; tag_waddr = free_slot_ff; tag_wdata = TagLive; rec_we = 1'b1;
         end else if (job_ff.req_type == ReqDelete && hit_ff) begin
            tag_we = 1'b1; tag_waddr = hit_slot_ff; tag_wdata = TagTomb;
         end
      end
   end

   djb2_ram #(.Width(2), .Depth(TableDepth)) u_tag_ram (
      .clock, .wr_en(tag_we), .wr_addr(tag_waddr), .wr_data(tag_wdata),
      .rd_addr(addr_ff), .rd_data(tag_rd)
   );

   djb2_ram #(.Width(RecBits), .Depth(TableDepth)) u_rec_ram (
      .clock, .wr_en(rec_we), .wr_addr(free_slot_ff),
      .wr_data({job_ff.value, job_ff.len, job_ff.key}),
      .rd_addr(addr_ff), .rd_data(rec_rd)
   );

   // probe sequencer: each slot is read in S_READ and checked in S_CHECK
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         addr_ff  <= '0;
         count_ff <= '0;
      end else begin
         unique case (state_ff)
            S_CLEAR: begin
               addr_ff <= addr_ff + 1'b1;
               if (addr_ff == SlotBits'(TableDepth - 1)) state_ff <= S_IDLE;
            end
            S_IDLE: begin
               if (job_valid) begin
                  job_ff       <= job;
                  addr_ff      <= job.home;
                  visited_ff   <= '0;
                  hit_ff       <= 1'b0;
                  have_free_ff <= 1'b0;
                  state_ff     <= S_READ;
               end
            end
            S_READ: state_ff <= S_CHECK;
            S_CHECK: begin
               if (tag_rd == TagEmpty) begin
                  if (!have_free_ff) begin
                     have_free_ff <= 1'b1;
                     free_slot_ff <= addr_ff;
                  end
                  state_ff <= S_WRITE;
               end else if (match) begin
                  hit_ff      <= 1'b1;
                  hit_slot_ff <= addr_ff;
                  val_out_ff  <= rd_val;
                  state_ff    <= S_WRITE;
               end else begin
                  if (tag_rd != TagLive && !have_free_ff) begin
                     have_free_ff <= 1'b1;
                     free_slot_ff <= addr_ff;
                  end
                  addr_ff    <= addr_ff + 1'b1;
                  visited_ff <= visited_ff + 1'b1;
                  if (visited_ff == (SlotBits+1)'(TableDepth - 1)) state_ff <= S_WRITE;
                  else state_ff <= S_READ;
               end
            end
            S_WRITE: begin
               case (job_ff.req_type)
                  ReqInsert: begin
                     if (hit_ff) begin
                        status_ff   <= StDuplicate;
                        slot_out_ff <= '0;
                     end else if (have_free_ff) begin
                        status_ff   <= StInserted;
                        slot_out_ff <= free_slot_ff;
                        count_ff    <= count_ff + 1'b1;
                     end else begin
                        status_ff   <= StFull;
                        slot_out_ff <= '0;
                     end
                  end
                  ReqLookup: begin
                     if (hit_ff) begin
                        status_ff   <= StFound;
                        slot_out_ff <= hit_slot_ff;
                     end else begin
                        status_ff   <= StAbsent;
                        slot_out_ff <= '0;
                     end
                  end
                  ReqDelete: begin
                     if (hit_ff) begin
                        status_ff   <= StDeleted;
                        slot_out_ff <= hit_slot_ff;
                        if (count_ff != '0) count_ff <= count_ff - 1'b1;
                     end else begin
                        status_ff   <= StAbsent;
                        slot_out_ff <= '0;
                     end
                  end
                  default: begin
                     status_ff   <= StAbsent;
                     slot_out_ff <= '0;
                  end
               endcase
               if (!(job_ff.req_type == ReqLookup && hit_ff)) val_out_ff <= '0;
               state_ff <= S_OUT;
            end
            S_OUT: begin
               if (rsp_tready) state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign job_ready  = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_OUT);
   assign rsp_tdata  = {count_ff, val_out_ff, slot_out_ff, status_ff};

endmodule

// File: rtl/djb2_checker.sv
module djb2_checker import djb2_pkg::*; (
   input logic         clock,
   input logic         reset,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [55:0]  rsp_tdata
);

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // status code is always a defined one
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[2:0] <= StFull)
      else $error("bad status");

   // only a found result carries a value
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[2:0] != StFound |-> rsp_tdata[44:13] == 32'd0)
      else $error("value without found");

   // absent, duplicate and full carry slot zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[2:0] == StDuplicate || rsp_tdata[2:0] == StAbsent ||
                     rsp_tdata[2:0] == StFull) |-> rsp_tdata[12:3] == 10'd0)
      else $error("slot on a miss");

endmodule

bind djb2_linear_probe_hash_table_unit djb2_checker u_checker (
   .clock, .reset, .rsp_tvalid, .rsp_tready, .rsp_tdata
);
